// ----- rtl/avcsps_pkg.sv -----
// ----------------------------------------------------------------------------
// avcsps_pkg
// Shared codes, types and helpers of the AVC SPS header parser.
// ----------------------------------------------------------------------------
package avcsps_pkg;

    // Result status codes
    localparam logic [2:0] STS_OK          = 3'd0;
    localparam logic [2:0] STS_NO_SPS      = 3'd1;
    localparam logic [2:0] STS_NOT_SPS_NAL = 3'd2;
    localparam logic [2:0] STS_TRUNC       = 3'd3;
    localparam logic [2:0] STS_SCALING     = 3'd4;
    localparam logic [2:0] STS_GOLOMB      = 3'd5;
    localparam logic [2:0] STS_BAD_SIZE    = 3'd6;

    // Longest accepted exp-Golomb prefix
    localparam logic [4:0] GOLOMB_MAX_ZEROS = 5'd31;

    // Header byte steps
    localparam logic [5:0] ST_VERSION     = 6'd0;
    localparam logic [5:0] ST_PROFILE     = 6'd1;
    localparam logic [5:0] ST_COMPAT      = 6'd2;
    localparam logic [5:0] ST_LEVEL       = 6'd3;
    localparam logic [5:0] ST_NAL_LEN     = 6'd4;
    localparam logic [5:0] ST_NUM_SPS     = 6'd5;
    localparam logic [5:0] ST_NAL_HDR     = 6'd8;
    localparam logic [5:0] ST_PROFILE_IDC = 6'd9;
    // SPS bit steps
    localparam logic [5:0] ST_SPS_ID    = 6'd12;
    localparam logic [5:0] ST_CHROMA    = 6'd13;
    localparam logic [5:0] ST_SEP       = 6'd14;
    localparam logic [5:0] ST_DEPTH_L   = 6'd15;
    localparam logic [5:0] ST_DEPTH_C   = 6'd16;
    localparam logic [5:0] ST_BYPASS    = 6'd17;
    localparam logic [5:0] ST_MATRIX    = 6'd18;
    localparam logic [5:0] ST_LISTS     = 6'd19;
    localparam logic [5:0] ST_LOG2FN    = 6'd20;
    localparam logic [5:0] ST_POC       = 6'd21;
    localparam logic [5:0] ST_MAX_POC   = 6'd22;
    localparam logic [5:0] ST_DELTA0    = 6'd23;
    localparam logic [5:0] ST_OFF_NR    = 6'd24;
    localparam logic [5:0] ST_OFF_TB    = 6'd25;
    localparam logic [5:0] ST_CYCLE     = 6'd26;
    localparam logic [5:0] ST_CYCLE_OFF = 6'd27;
    localparam logic [5:0] ST_NUM_REF   = 6'd28;
    localparam logic [5:0] ST_GAPS      = 6'd29;
    localparam logic [5:0] ST_WIDTH     = 6'd30;
    localparam logic [5:0] ST_HEIGHT    = 6'd31;
    localparam logic [5:0] ST_FMO       = 6'd32;
    localparam logic [5:0] ST_MBAFF     = 6'd33;
    localparam logic [5:0] ST_DIRECT    = 6'd34;
    localparam logic [5:0] ST_CROPF     = 6'd35;
    localparam logic [5:0] ST_CL        = 6'd36;
    localparam logic [5:0] ST_CR        = 6'd37;
    localparam logic [5:0] ST_CT        = 6'd38;
    localparam logic [5:0] ST_CB        = 6'd39;
    localparam logic [5:0] ST_DONE      = 6'd40;

    localparam logic [7:0] SPS_NAL_HDR = 8'h67;

    typedef struct packed {
        logic en;
        logic bin;
        logic clear;
    } golomb_ctl_t;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [31:0] value;
    } golomb_res_t;

    function automatic logic high_profile(input logic [7:0] p);
        return (p == 8'd100) || (p == 8'd110) || (p == 8'd122) || (p == 8'd244) ||
               (p == 8'd44) || (p == 8'd83) || (p == 8'd86) || (p == 8'd118);
    endfunction

    function automatic logic is_golomb_step(input logic [5:0] s);
        return (s == ST_SPS_ID) || (s == ST_CHROMA) || (s == ST_DEPTH_L) ||
               (s == ST_DEPTH_C) || (s == ST_LOG2FN) || (s == ST_POC) ||
               (s == ST_MAX_POC) || (s == ST_OFF_NR) || (s == ST_OFF_TB) ||
               (s == ST_CYCLE) || (s == ST_CYCLE_OFF) || (s == ST_NUM_REF) ||
               (s == ST_WIDTH) || (s == ST_HEIGHT) || (s == ST_CL) ||
               (s == ST_CR) || (s == ST_CT) || (s == ST_CB);
    endfunction

endpackage

// ----- rtl/avcsps_if.sv -----
// ----------------------------------------------------------------------------
// avcsps_in_if / avcsps_out_if
// Valid/ready channels carrying record bytes in and parse results out.
// ----------------------------------------------------------------------------
interface avcsps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface avcsps_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  profile;
    logic [7:0]  compat;
    logic [7:0]  level;
    logic [2:0]  nal_length_size;
    logic [7:0]  ref_frames;
    logic [15:0] pixel_width;
    logic [15:0] pixel_height;

    modport source (output valid, output status, output profile, output compat,
                    output level, output nal_length_size, output ref_frames,
                    output pixel_width, output pixel_height, input ready);
    modport sink   (input valid, input status, input profile, input compat,
                    input level, input nal_length_size, input ref_frames,
                    input pixel_width, input pixel_height, output ready);
endinterface

// ----- rtl/avc_sps_header_parser.sv -----
// ----------------------------------------------------------------------------
// avc_sps_header_parser
// Parses an AVC decoder configuration record and its first SPS, giving the
// header bytes, reference frame count and cropped picture size.
// ----------------------------------------------------------------------------
// Header bytes (before the SPS payload) and bytes after the parse ends are
// used on acceptance. SPS payload bytes go through an 8-bit shift register
// one bit per cycle; a new byte is taken only once the shifter is empty,
// and the shift stops early when the parse ends. The result is registered:
// it appears the cycle after the last byte's final bit is done. rst_n clears
// the parser to the first header byte and empties the output register.
module avc_sps_header_parser
    import avcsps_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    avcsps_in_if.sink     in_item,
    avcsps_out_if.source  out_item
);

    // parse control
    logic [5:0]  step_reg, step_next;
    logic [7:0]  shift_reg, shift_next;
    logic [3:0]  cnt_reg, cnt_next;          // bits left in the current byte
    logic        last_reg, last_next;
    logic [31:0] loop_reg, loop_next;

    // captured SPS fields
    logic [7:0]  pidc_reg, pidc_next;
    logic [1:0]  chroma_reg, chroma_next;
    logic        sep_reg, sep_next;
    logic [31:0] w_reg, w_next;
    logic [31:0] h_reg, h_next;
    logic        frame_reg, frame_next;
    logic [32:0] crop0_reg, crop0_next;
    logic [32:0] crop1_reg, crop1_next;

    // result fields
    logic [7:0]  prof_reg, prof_next;
    logic [7:0]  compat_reg, compat_next;
    logic [7:0]  level_reg, level_next;
    logic [2:0]  nal_reg, nal_next;
    logic [7:0]  ref_reg, ref_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [2:0]  err_reg, err_next;

    // output register
    logic        out_valid_reg;
    logic [2:0]  o_status_reg;
    logic [7:0]  o_prof_reg, o_compat_reg, o_level_reg, o_ref_reg;
    logic [2:0]  o_nal_reg;
    logic [15:0] o_width_reg, o_height_reg;

    logic        busy, in_fire, emit, bit_in, finish;
    logic [2:0]  status_next;
    golomb_ctl_t g_ctl;
    golomb_res_t g_res;

    // size check
    logic [1:0]  ct;
    logic        ux2;
    logic [1:0]  sy;
    logic [32:0] wp1, hp1;
    logic [37:0] fw, fh, cw, ch, dw, dh;
    logic        bad_size;

    assign busy          = (cnt_reg != 4'd0);
    assign in_item.ready = !busy && (!out_valid_reg || out_item.ready);
    assign in_fire       = in_item.valid && in_item.ready;
    assign bit_in        = shift_reg[7];

    avcsps_golomb u_golomb (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (g_ctl),
        .res   (g_res)
    );

    // Cropped size from the captured fields; crop1_next carries the bottom
    // offset added in the same cycle.
    always_comb
    begin
        ct  = sep_reg ? 2'd0 : chroma_reg;
        ux2 = (ct == 2'd1) || (ct == 2'd2);
        if (ct == 2'd1)
            sy = frame_reg ? 2'd1 : 2'd2;
        else
            sy = frame_reg ? 2'd0 : 2'd1;
        wp1 = {1'b0, w_reg} + 33'd1;
        hp1 = {1'b0, h_reg} + 33'd1;
        fw  = {1'b0, wp1, 4'b0000};
        fh  = frame_reg ? {1'b0, hp1, 4'b0000} : {hp1, 5'b00000};
        cw  = ux2 ? {4'b0000, crop0_next, 1'b0} : {5'b00000, crop0_next};
        ch  = {5'b00000, crop1_next} << sy;
        dw  = fw - cw;
        dh  = fh - ch;
        bad_size = (cw >= fw) || (ch >= fh) || (dw[37:16] != 22'd0) ||
                   (dh[37:16] != 22'd0);
    end

    always_comb
    begin
        step_next   = step_reg;
        shift_next  = shift_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        loop_next   = loop_reg;
        pidc_next   = pidc_reg;
        chroma_next = chroma_reg;
        sep_next    = sep_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        frame_next  = frame_reg;
        crop0_next  = crop0_reg;
        crop1_next  = crop1_reg;
        prof_next   = prof_reg;
        compat_next = compat_reg;
        level_next  = level_reg;
        nal_next    = nal_reg;
        ref_next    = ref_reg;
        width_next  = width_reg;
        height_next = height_reg;
        err_next    = err_reg;
        emit        = 1'b0;
        finish      = 1'b0;
        g_ctl.en    = 1'b0;
        g_ctl.bin   = bit_in;

        if (in_fire)
        begin
            if (step_reg < ST_SPS_ID)
            begin
                // header byte: capture or check, then advance
                step_next = step_reg + 6'd1;
                unique case (step_reg)
                    ST_PROFILE:     prof_next   = in_item.data_byte;
                    ST_COMPAT:      compat_next = in_item.data_byte;
                    ST_LEVEL:       level_next  = in_item.data_byte;
                    ST_NAL_LEN:     nal_next    = {1'b0, in_item.data_byte[1:0]} + 3'd1;
                    ST_NUM_SPS:
                    begin
                        if (in_item.data_byte[4:0] == 5'd0)
                        begin
                            err_next  = STS_NO_SPS;
                            step_next = ST_DONE;
                        end
                    end
                    ST_NAL_HDR:
                    begin
                        if (in_item.data_byte != SPS_NAL_HDR)
                        begin
                            err_next  = STS_NOT_SPS_NAL;
                            step_next = ST_DONE;
                        end
                    end
                    ST_PROFILE_IDC: pidc_next = in_item.data_byte;
                    default:        ;
                endcase
                emit = in_item.last_byte;
            end
            else if (step_reg == ST_DONE)
            begin
                // drop bytes after the parse has ended
                emit = in_item.last_byte;
            end
            else
            begin
                // SPS payload byte: load the shifter
                shift_next = in_item.data_byte;
                cnt_next   = 4'd8;
                last_next  = in_item.last_byte;
            end
        end
        else if (busy)
        begin
            g_ctl.en = is_golomb_step(step_reg);
            if (g_ctl.en && g_res.ovf)
            begin
                err_next  = STS_GOLOMB;
                step_next = ST_DONE;
            end
            else if (!g_ctl.en || g_res.done)
            begin
                unique case (step_reg)
                    ST_SPS_ID:
                        step_next = high_profile(pidc_reg) ? ST_CHROMA : ST_LOG2FN;
                    ST_CHROMA:
                    begin
                        chroma_next = (g_res.value <= 32'd3) ? g_res.value[1:0] : 2'd1;
                        step_next   = (g_res.value == 32'd3) ? ST_SEP : ST_DEPTH_L;
                    end
                    ST_SEP:
                    begin
                        sep_next  = bit_in;
                        step_next = ST_DEPTH_L;
                    end
                    ST_DEPTH_L: step_next = ST_DEPTH_C;
                    ST_DEPTH_C: step_next = ST_BYPASS;
                    ST_BYPASS:  step_next = ST_MATRIX;
                    ST_MATRIX:
                    begin
                        if (bit_in)
                        begin
                            loop_next = (chroma_reg == 2'd3) ? 32'd12 : 32'd8;
                            step_next = ST_LISTS;
                        end
                        else
                        begin
                            step_next = ST_LOG2FN;
                        end
                    end
                    ST_LISTS:
                    begin
                        if (bit_in)
                        begin
                            err_next  = STS_SCALING;
                            step_next = ST_DONE;
                        end
                        else
                        begin
                            loop_next = loop_reg - 32'd1;
                            if (loop_next == 32'd0)
                                step_next = ST_LOG2FN;
                        end
                    end
                    ST_LOG2FN: step_next = ST_POC;
                    ST_POC:
                    begin
                        if (g_res.value == 32'd0)
                            step_next = ST_MAX_POC;
                        else if (g_res.value == 32'd1)
                            step_next = ST_DELTA0;
                        else
                            step_next = ST_NUM_REF;
                    end
                    ST_MAX_POC: step_next = ST_NUM_REF;
                    ST_DELTA0:  step_next = ST_OFF_NR;
                    ST_OFF_NR:  step_next = ST_OFF_TB;
                    ST_OFF_TB:  step_next = ST_CYCLE;
                    ST_CYCLE:
                    begin
                        loop_next = g_res.value;
                        step_next = (g_res.value == 32'd0) ? ST_NUM_REF : ST_CYCLE_OFF;
                    end
                    ST_CYCLE_OFF:
                    begin
                        loop_next = loop_reg - 32'd1;
                        if (loop_next == 32'd0)
                            step_next = ST_NUM_REF;
                    end
                    ST_NUM_REF:
                    begin
                        ref_next  = (g_res.value > 32'd255) ? 8'd255 : g_res.value[7:0];
                        step_next = ST_GAPS;
                    end
                    ST_GAPS: step_next = ST_WIDTH;
                    ST_WIDTH:
                    begin
                        w_next    = g_res.value;
                        step_next = ST_HEIGHT;
                    end
                    ST_HEIGHT:
                    begin
                        h_next    = g_res.value;
                        step_next = ST_FMO;
                    end
                    ST_FMO:
                    begin
                        frame_next = bit_in;
                        step_next  = bit_in ? ST_DIRECT : ST_MBAFF;
                    end
                    ST_MBAFF:  step_next = ST_DIRECT;
                    ST_DIRECT: step_next = ST_CROPF;
                    ST_CROPF:
                    begin
                        if (bit_in)
                            step_next = ST_CL;
                        else
                            finish = 1'b1;
                    end
                    ST_CL:
                    begin
                        crop0_next = {1'b0, g_res.value};
                        step_next  = ST_CR;
                    end
                    ST_CR:
                    begin
                        crop0_next = crop0_reg + {1'b0, g_res.value};
                        step_next  = ST_CT;
                    end
                    ST_CT:
                    begin
                        crop1_next = {1'b0, g_res.value};
                        step_next  = ST_CB;
                    end
                    ST_CB:
                    begin
                        crop1_next = crop1_reg + {1'b0, g_res.value};
                        finish     = 1'b1;
                    end
                    default: step_next = ST_DONE;
                endcase
            end

            if (finish)
            begin
                step_next = ST_DONE;
                if (bad_size)
                begin
                    err_next = STS_BAD_SIZE;
                end
                else
                begin
                    err_next    = STS_OK;
                    width_next  = dw[15:0];
                    height_next = dh[15:0];
                end
            end

            // advance the shifter; stop early once the parse has ended
            shift_next = {shift_reg[6:0], 1'b0};
            cnt_next   = (step_next == ST_DONE) ? 4'd0 : cnt_reg - 4'd1;
            emit       = last_reg && (cnt_next == 4'd0);
        end

        g_ctl.clear = emit;
        status_next = (step_next == ST_DONE) ? err_next : STS_TRUNC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= ST_VERSION;
            cnt_reg    <= '0;
            last_reg   <= 1'b0;
            loop_reg   <= '0;
            pidc_reg   <= '0;
            chroma_reg <= 2'd1;
            sep_reg    <= 1'b0;
            w_reg      <= '0;
            h_reg      <= '0;
            frame_reg  <= 1'b0;
            crop0_reg  <= '0;
            crop1_reg  <= '0;
            prof_reg   <= '0;
            compat_reg <= '0;
            level_reg  <= '0;
            nal_reg    <= '0;
            ref_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            err_reg    <= STS_OK;
        end
        else if (emit)
        begin
            // result taken: return to the first header byte
            step_reg   <= ST_VERSION;
            cnt_reg    <= '0;
            last_reg   <= 1'b0;
            loop_reg   <= '0;
            pidc_reg   <= '0;
            chroma_reg <= 2'd1;
            sep_reg    <= 1'b0;
            w_reg      <= '0;
            h_reg      <= '0;
            frame_reg  <= 1'b0;
            crop0_reg  <= '0;
            crop1_reg  <= '0;
            prof_reg   <= '0;
            compat_reg <= '0;
            level_reg  <= '0;
            nal_reg    <= '0;
            ref_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            err_reg    <= STS_OK;
        end
        else
        begin
            step_reg   <= step_next;
            cnt_reg    <= cnt_next;
            last_reg   <= last_next;
            loop_reg   <= loop_next;
            pidc_reg   <= pidc_next;
            chroma_reg <= chroma_next;
            sep_reg    <= sep_next;
            w_reg      <= w_next;
            h_reg      <= h_next;
            frame_reg  <= frame_next;
            crop0_reg  <= crop0_next;
            crop1_reg  <= crop1_next;
            prof_reg   <= prof_next;
            compat_reg <= compat_next;
            level_reg  <= level_next;
            nal_reg    <= nal_next;
            ref_reg    <= ref_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            err_reg    <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    // output register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_item.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            o_status_reg <= status_next;
            o_prof_reg   <= prof_next;
            o_compat_reg <= compat_next;
            o_level_reg  <= level_next;
            o_nal_reg    <= nal_next;
            o_ref_reg    <= (status_next == STS_OK) ? ref_next : 8'd0;
            o_width_reg  <= (status_next == STS_OK) ? width_next : 16'd0;
            o_height_reg <= (status_next == STS_OK) ? height_next : 16'd0;
        end
    end

    assign out_item.valid           = out_valid_reg;
    assign out_item.status          = o_status_reg;
    assign out_item.profile         = o_prof_reg;
    assign out_item.compat          = o_compat_reg;
    assign out_item.level           = o_level_reg;
    assign out_item.nal_length_size = o_nal_reg;
    assign out_item.ref_frames      = o_ref_reg;
    assign out_item.pixel_width     = o_width_reg;
    assign out_item.pixel_height    = o_height_reg;

endmodule

// ----- rtl/avcsps_golomb.sv -----
// ----------------------------------------------------------------------------
// avcsps_golomb
// Bit-serial unsigned exp-Golomb decoder: one code bit per enabled cycle.
// ----------------------------------------------------------------------------
module avcsps_golomb
    import avcsps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  golomb_ctl_t ctl,
    output golomb_res_t res
);

    logic        suffix_reg, suffix_next;
    logic [4:0]  zc_reg, zc_next;
    logic [31:0] val_reg, val_next;
    logic [31:0] shifted;

    always_comb
    begin
        suffix_next = suffix_reg;
        zc_next     = zc_reg;
        val_next    = val_reg;
        res         = '0;
        shifted     = {val_reg[30:0], ctl.bin};
        if (ctl.en)
        begin
            if (!suffix_reg)
            begin
                if (!ctl.bin)
                begin
                    if (zc_reg >= GOLOMB_MAX_ZEROS)
                        res.ovf = 1'b1;
                    else
                        zc_next = zc_reg + 5'd1;
                end
                else if (zc_reg == 5'd0)
                begin
                    res.done = 1'b1;
                end
                else
                begin
                    suffix_next = 1'b1;
                    val_next    = 32'd1;
                end
            end
            else
            begin
                // append suffix bit, finish when the prefix count runs out
                zc_next = zc_reg - 5'd1;
                if (zc_next == 5'd0)
                begin
                    res.done    = 1'b1;
                    res.value   = shifted - 32'd1;
                    suffix_next = 1'b0;
                    val_next    = '0;
                end
                else
                begin
                    val_next = shifted;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            suffix_reg <= 1'b0;
            zc_reg     <= '0;
            val_reg    <= '0;
        end
        else if (ctl.clear)
        begin
            suffix_reg <= 1'b0;
            zc_reg     <= '0;
            val_reg    <= '0;
        end
        else
        begin
            suffix_reg <= suffix_next;
            zc_reg     <= zc_next;
            val_reg    <= val_next;
        end
    end

endmodule

// ----- rtl/avcsps_checker.sv -----
// ----------------------------------------------------------------------------
// avcsps_checker
// Port-level checks of the AVC SPS header parser, bound to the top level.
// ----------------------------------------------------------------------------
module avcsps_checker
    import avcsps_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [2:0]  nal_length_size,
    input logic [7:0]  ref_frames,
    input logic [15:0] pixel_width,
    input logic [15:0] pixel_height
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(pixel_width) && $stable(pixel_height))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= STS_BAD_SIZE)
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STS_OK |->
        ref_frames == 8'd0 && pixel_width == 16'd0 && pixel_height == 16'd0)
        else $error("SPS fields given on a failed parse");

    a_ok_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STS_OK |->
        pixel_width != 16'd0 && pixel_height != 16'd0 && nal_length_size != 3'd0 &&
        nal_length_size <= 3'd4)
        else $error("good parse with empty size or bad NAL length size");

endmodule

bind avc_sps_header_parser avcsps_checker u_avcsps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_item.valid),
    .out_ready       (out_item.ready),
    .status          (out_item.status),
    .nal_length_size (out_item.nal_length_size),
    .ref_frames      (out_item.ref_frames),
    .pixel_width     (out_item.pixel_width),
    .pixel_height    (out_item.pixel_height)
);

// ----- sim/avc_sps_header_parser_test.sv -----
// ----------------------------------------------------------------------------
// avc_sps_header_parser_test
// Streams AVC configuration records, most of them carrying a well-formed SPS
// with random content, through the parser. A bit-level predictor tracks the
// same parse and checks every result, field by field, in arrival order.
// ----------------------------------------------------------------------------
module avc_sps_header_parser_test;
    import avcsps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1850;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  profile;
        logic [7:0]  compat;
        logic [7:0]  level;
        logic [2:0]  nal_length_size;
        logic [7:0]  ref_frames;
        logic [15:0] pixel_width;
        logic [15:0] pixel_height;
    } sps_result_t;

    // One record byte as offered on the input channel.
    typedef struct {
        bit [7:0] d;
        bit       l;
    } rec_byte_t;

    // Knobs that shape one generated SPS.
    typedef struct {
        bit [7:0]        prof;
        longint unsigned chroma;
        bit              sep;
        bit              matrix;
        int              bad_list;   // index of the set list flag, -1 for none
        longint unsigned poc;
        longint unsigned ncycle;
        longint unsigned nref;
        longint unsigned w;
        longint unsigned h;
        bit              fonly;
        bit              cropf;
        longint unsigned cl, cr, ct, cb;
        bit              overflow;   // long zero run in place of the SPS id
    } sps_knobs_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts each record's result and checks arrivals.
    // ------------------------------------------------------------------------
    class sps_scoreboard;
        sps_result_t     pending[$];
        int              errors;
        logic [5:0]      step;
        bit              gsuf;
        int unsigned     gz;
        longint unsigned gval, loopc, wmbs, hunits;
        longint unsigned crop[2];
        bit [7:0]        prof_idc;
        longint unsigned chroma;
        bit              sep, fonly;
        bit [7:0]        hp, hc, hl, refv;
        bit [2:0]        hn, err;
        bit [15:0]       wv, hv;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            step = ST_VERSION;
            gsuf = 0; gz = 0; gval = 0; loopc = 0;
            prof_idc = 0; chroma = 1; sep = 0;
            wmbs = 0; hunits = 0; fonly = 0;
            crop[0] = 0; crop[1] = 0;
            hp = 0; hc = 0; hl = 0; hn = 0;
            refv = 0; wv = 0; hv = 0; err = STS_OK;
        endfunction

        function void fail_with(bit [2:0] code);
            err = code;
            step = ST_DONE;
        endfunction

        function bit is_high(bit [7:0] p);
            case (p)
                8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86, 8'd118: return 1;
                default: return 0;
            endcase
        endfunction

        function bit reads_ue(logic [5:0] s);
            case (s)
                ST_SPS_ID, ST_CHROMA, ST_DEPTH_L, ST_DEPTH_C, ST_LOG2FN, ST_POC,
                ST_MAX_POC, ST_OFF_NR, ST_OFF_TB, ST_CYCLE, ST_CYCLE_OFF, ST_NUM_REF,
                ST_WIDTH, ST_HEIGHT, ST_CL, ST_CR, ST_CT, ST_CB: return 1;
                default: return 0;
            endcase
        endfunction

        // 1: code complete, 0: pending, -1: prefix too long
        function int ue_bit(bit b, output longint unsigned v);
            v = 0;
            if (!gsuf) begin
                if (b == 0) begin
                    if (gz >= GOLOMB_MAX_ZEROS)
                        return -1;
                    gz++;
                    return 0;
                end
                if (gz == 0)
                    return 1;
                gsuf = 1;
                gval = 1;
                return 0;
            end
            gval = (gval << 1) | b;
            gz--;
            if (gz != 0)
                return 0;
            gsuf = 0;
            v = gval - 1;
            gval = 0;
            return 1;
        endfunction

        function void size_out();
            longint unsigned ct, fields, ux, uy, fw, fh, cw, chh;
            ct = sep ? 0 : chroma;
            fields = 2 - fonly;
            ux = (ct == 1 || ct == 2) ? 2 : 1;
            uy = (ct == 1 ? 2 : 1) * fields;
            fw = (wmbs + 1) * 16;
            fh = fields * (hunits + 1) * 16;
            cw = ux * crop[0];
            chh = uy * crop[1];
            step = ST_DONE;
            if (cw >= fw || chh >= fh || fw - cw > 65535 || fh - chh > 65535) begin
                err = STS_BAD_SIZE;
                return;
            end
            wv = 16'(fw - cw);
            hv = 16'(fh - chh);
            err = STS_OK;
        endfunction

        function void byte_in(bit [7:0] d);
            case (step)
                ST_PROFILE: hp = d;
                ST_COMPAT:  hc = d;
                ST_LEVEL:   hl = d;
                ST_NAL_LEN: hn = {1'b0, d[1:0]} + 3'd1;
                ST_NUM_SPS:
                    if (d[4:0] == 0) begin
                        fail_with(STS_NO_SPS);
                        return;
                    end
                ST_NAL_HDR:
                    if (d != SPS_NAL_HDR) begin
                        fail_with(STS_NOT_SPS_NAL);
                        return;
                    end
                ST_PROFILE_IDC: prof_idc = d;
                default: ;
            endcase
            step++;
        endfunction

        function void bit_in(bit b);
            longint unsigned v;
            int r;
            v = 0;
            if (reads_ue(step)) begin
                r = ue_bit(b, v);
                if (r < 0) begin
                    fail_with(STS_GOLOMB);
                    return;
                end
                if (r == 0)
                    return;
            end
            case (step)
                ST_SPS_ID:  step = is_high(prof_idc) ? ST_CHROMA : ST_LOG2FN;
                ST_CHROMA: begin
                    chroma = (v <= 3) ? v : 1;
                    step = (v == 3) ? ST_SEP : ST_DEPTH_L;
                end
                ST_SEP: begin
                    sep = b;
                    step = ST_DEPTH_L;
                end
                ST_DEPTH_L: step = ST_DEPTH_C;
                ST_DEPTH_C: step = ST_BYPASS;
                ST_BYPASS:  step = ST_MATRIX;
                ST_MATRIX:
                    if (b) begin
                        loopc = (chroma == 3) ? 12 : 8;
                        step = ST_LISTS;
                    end else
                        step = ST_LOG2FN;
                ST_LISTS: begin
                    if (b) begin
                        fail_with(STS_SCALING);
                        return;
                    end
                    loopc--;
                    if (loopc == 0)
                        step = ST_LOG2FN;
                end
                ST_LOG2FN:  step = ST_POC;
                ST_POC:     step = (v == 0) ? ST_MAX_POC : (v == 1) ? ST_DELTA0 : ST_NUM_REF;
                ST_MAX_POC: step = ST_NUM_REF;
                ST_DELTA0:  step = ST_OFF_NR;
                ST_OFF_NR:  step = ST_OFF_TB;
                ST_OFF_TB:  step = ST_CYCLE;
                ST_CYCLE: begin
                    loopc = v;
                    step = (v == 0) ? ST_NUM_REF : ST_CYCLE_OFF;
                end
                ST_CYCLE_OFF: begin
                    loopc--;
                    if (loopc == 0)
                        step = ST_NUM_REF;
                end
                ST_NUM_REF: begin
                    refv = (v > 255) ? 8'd255 : v[7:0];
                    step = ST_GAPS;
                end
                ST_GAPS: step = ST_WIDTH;
                ST_WIDTH: begin
                    wmbs = v;
                    step = ST_HEIGHT;
                end
                ST_HEIGHT: begin
                    hunits = v;
                    step = ST_FMO;
                end
                ST_FMO: begin
                    fonly = b;
                    step = b ? ST_DIRECT : ST_MBAFF;
                end
                ST_MBAFF:  step = ST_DIRECT;
                ST_DIRECT: step = ST_CROPF;
                ST_CROPF:
                    if (b)
                        step = ST_CL;
                    else
                        size_out();
                ST_CL: begin
                    crop[0] = v;
                    step = ST_CR;
                end
                ST_CR: begin
                    crop[0] += v;
                    step = ST_CT;
                end
                ST_CT: begin
                    crop[1] = v;
                    step = ST_CB;
                end
                ST_CB: begin
                    crop[1] += v;
                    size_out();
                end
                default: step = ST_DONE;
            endcase
        endfunction

        // Advance the parse by one accepted item; queue a result on the last byte.
        function void note_item(bit [7:0] d, bit l);
            sps_result_t res;
            if (step < ST_SPS_ID)
                byte_in(d);
            else
                for (int i = 7; i >= 0 && step != ST_DONE; i--)
                    bit_in(d[i]);
            if (!l)
                return;
            res.status = (step == ST_DONE) ? err : STS_TRUNC;
            res.profile = hp;
            res.compat = hc;
            res.level = hl;
            res.nal_length_size = hn;
            res.ref_frames = (res.status == STS_OK) ? refv : 8'd0;
            res.pixel_width = (res.status == STS_OK) ? wv : 16'd0;
            res.pixel_height = (res.status == STS_OK) ? hv : 16'd0;
            pending.push_back(res);
            clear();
        endfunction

        function void check_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(sps_result_t got);
            sps_result_t want;
            if (pending.size() == 0) begin
                $error("result with no record pending");
                errors++;
                return;
            end
            want = pending.pop_front();
            check_field("status", want.status, got.status);
            check_field("profile", want.profile, got.profile);
            check_field("compat", want.compat, got.compat);
            check_field("level", want.level, got.level);
            check_field("nal_length_size", want.nal_length_size, got.nal_length_size);
            check_field("ref_frames", want.ref_frames, got.ref_frames);
            check_field("pixel_width", want.pixel_width, got.pixel_width);
            check_field("pixel_height", want.pixel_height, got.pixel_height);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles;

    avcsps_in_if  in_ch();
    avcsps_out_if out_ch();

    avc_sps_header_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_ch),
        .out_item (out_ch)
    );

    sps_scoreboard sb = new();
    rec_byte_t     feed[$];
    bit            sps_bits[$];

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Hard stop if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Record generation
    // ------------------------------------------------------------------------

    // Append v as an unsigned exp-Golomb code.
    function automatic void put_ue(longint unsigned v);
        longint unsigned x;
        int n;
        x = v + 1;
        n = 0;
        while ((x >> (n + 1)) != 0)
            n++;
        repeat (n) sps_bits.push_back(1'b0);
        for (int i = n; i >= 0; i--)
            sps_bits.push_back(x[i]);
    endfunction

    function automatic void put_bit(bit b);
        sps_bits.push_back(b);
    endfunction

    // Mostly small values, now and then a large one.
    function automatic longint unsigned pick_ue(int unsigned small_max);
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, 100000);
        return $urandom_range(0, small_max);
    endfunction

    function automatic sps_knobs_t random_knobs();
        sps_knobs_t k;
        bit [7:0] highs[8] = '{100, 110, 122, 244, 44, 83, 86, 118};
        k.prof = $urandom_range(0, 1) ? highs[$urandom_range(0, 7)] : 8'($urandom);
        k.chroma = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 300) : $urandom_range(0, 3);
        k.sep = 1'($urandom_range(0, 1));
        k.matrix = ($urandom_range(0, 4) == 0);
        k.bad_list = $urandom_range(0, 1) ? -1 : $urandom_range(0, 11);
        k.poc = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 40) : $urandom_range(0, 2);
        k.ncycle = $urandom_range(0, 4);
        k.nref = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 5000) : $urandom_range(0, 16);
        k.w = ($urandom_range(0, 15) == 0) ? $urandom_range(4000, 4200) : $urandom_range(0, 120);
        k.h = ($urandom_range(0, 15) == 0) ? $urandom_range(2000, 4200) : $urandom_range(0, 68);
        k.fonly = $urandom_range(0, 3) != 0;
        k.cropf = 1'($urandom_range(0, 1));
        k.cl = pick_ue(8);
        k.cr = pick_ue(8);
        k.ct = pick_ue(8);
        k.cb = pick_ue(8);
        k.overflow = ($urandom_range(0, 29) == 0);
        return k;
    endfunction

    // Queue one record: header, SPS NAL header, SPS bits, trailing bytes.
    // Cut it short when cut > 0.
    function automatic void add_record(sps_knobs_t k, bit [7:0] count_byte, bit [7:0] nal,
                                       int cut, int tail);
        bit [7:0] rec[$];
        bit [7:0] b;
        int nlists;
        rec.push_back(8'($urandom));
        rec.push_back($urandom_range(0, 1) ? k.prof : 8'($urandom));
        rec.push_back(8'($urandom));
        rec.push_back(8'($urandom));
        rec.push_back(8'($urandom));
        rec.push_back(count_byte);
        rec.push_back(8'($urandom));
        rec.push_back(8'($urandom));
        rec.push_back(nal);
        rec.push_back(k.prof);
        rec.push_back(8'($urandom));
        rec.push_back(8'($urandom));
        sps_bits.delete();
        if (k.overflow)
        begin
            repeat (32) put_bit(1'b0);
            put_bit(1'b1);
        end
        put_ue(pick_ue(31));
        if (k.prof inside {100, 110, 122, 244, 44, 83, 86, 118})
        begin
            put_ue(k.chroma);
            if (k.chroma == 3)
                put_bit(k.sep);
            put_ue(pick_ue(6));
            put_ue(pick_ue(6));
            put_bit(1'($urandom_range(0, 1)));
            put_bit(k.matrix);
            if (k.matrix)
            begin
                nlists = (k.chroma == 3) ? 12 : 8;
                for (int i = 0; i < nlists; i++)
                    put_bit(i == k.bad_list);
            end
        end
        put_ue(pick_ue(12));
        put_ue(k.poc);
        if (k.poc == 0)
            put_ue(pick_ue(12));
        else if (k.poc == 1)
        begin
            put_bit(1'($urandom_range(0, 1)));
            put_ue(pick_ue(40));
            put_ue(pick_ue(40));
            put_ue(k.ncycle);
            repeat (k.ncycle) put_ue(pick_ue(40));
        end
        put_ue(k.nref);
        put_bit(1'($urandom_range(0, 1)));
        put_ue(k.w);
        put_ue(k.h);
        put_bit(k.fonly);
        if (!k.fonly)
            put_bit(1'($urandom_range(0, 1)));
        put_bit(1'($urandom_range(0, 1)));
        put_bit(k.cropf);
        if (k.cropf)
        begin
            put_ue(k.cl);
            put_ue(k.cr);
            put_ue(k.ct);
            put_ue(k.cb);
        end
        // stop bit, then pad to a byte
        put_bit(1'b1);
        while (sps_bits.size() % 8 != 0)
            put_bit(1'b0);
        for (int i = 0; i < sps_bits.size(); i += 8)
        begin
            for (int j = 0; j < 8; j++)
                b[7 - j] = sps_bits[i + j];
            rec.push_back(b);
        end
        repeat (tail) rec.push_back(8'($urandom));
        if (cut > 0 && cut < rec.size())
            rec = rec[0:cut - 1];
        foreach (rec[i])
            feed.push_back('{d: rec[i], l: (i == rec.size() - 1)});
    endfunction

    // Random bytes; a valid-looking header now and then so the SPS walk sees noise.
    function automatic void add_noise();
        int n;
        n = $urandom_range(1, 24);
        for (int i = 0; i < n; i++)
            feed.push_back('{d: (i == 8 && $urandom_range(0, 1)) ? SPS_NAL_HDR : 8'($urandom),
                             l: (i == n - 1)});
    endfunction

    function automatic void build_stimulus();
        sps_knobs_t k;
        int r;
        // Directed part: plain baseline, each failure path and the size extremes.
        k = random_knobs();
        k.prof = 8'd66; k.poc = 2; k.nref = 1; k.w = 0; k.h = 0; k.fonly = 1;
        k.cropf = 0; k.overflow = 0;
        add_record(k, 8'hE1, SPS_NAL_HDR, 0, 0);
        feed.push_back('{d: 8'hFF, l: 1'b1});                 // last on the first byte
        add_record(k, 8'hE0, SPS_NAL_HDR, 0, 0);              // no SPS
        add_record(k, 8'hE1, 8'h68, 0, 0);                    // wrong NAL header
        add_record(k, 8'hE1, SPS_NAL_HDR, 11, 0);             // truncated early
        k.prof = 8'd100; k.chroma = 1; k.matrix = 1; k.bad_list = 3;
        add_record(k, 8'h01, SPS_NAL_HDR, 0, 0);              // scaling list
        k.matrix = 0; k.overflow = 1;
        add_record(k, 8'h1F, SPS_NAL_HDR, 0, 0);              // golomb overflow
        k.overflow = 0; k.chroma = 3; k.sep = 1; k.poc = 1; k.ncycle = 3; k.nref = 4000;
        k.w = 4094; k.h = 4094; k.fonly = 0; k.cropf = 1;
        k.cl = 0; k.cr = 0; k.ct = 0; k.cb = 0;
        add_record(k, 8'h21, SPS_NAL_HDR, 0, 3);              // too tall, trailing bytes
        k.chroma = 9; k.w = 4095; k.h = 10; k.fonly = 1;
        add_record(k, 8'h21, SPS_NAL_HDR, 0, 0);              // too wide, chroma above three
        k.chroma = 2; k.w = 3; k.cl = 40; k.cr = 40;
        add_record(k, 8'h21, SPS_NAL_HDR, 0, 0);              // crop eats the width
        // Random part: mostly well-formed records, some cut, some noise.
        while (feed.size() < ITEM_TARGET)
        begin
            r = $urandom_range(0, 9);
            k = random_knobs();
            if (r < 7)
                add_record(k, 8'($urandom_range(1, 255)) | 8'h01, SPS_NAL_HDR, 0,
                           $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0);
            else if (r == 7)
                add_record(k, 8'($urandom), SPS_NAL_HDR, $urandom_range(1, 20), 0);
            else if (r == 8)
                add_record(k, 8'($urandom), 8'($urandom), 0, 0);
            else
                add_noise();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item after an optional gap; hold it until accepted.
    task automatic send_item(rec_byte_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= it.d;
        in_ch.last_byte <= it.l;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_item(it.d, it.l);
    endtask

    // Ready toggles at random; one long hold-off lets the block fill and stall.
    task automatic drive_ready();
        int run, stall, seen;
        bit held;
        seen = 0;
        held = 0;
        forever
        begin
            run = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80) : $urandom_range(1, 6);
            stall = pick_gap();
            if (!held && seen > 2000)
            begin
                stall = 600;
                held = 1;
            end
            out_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            seen += run + stall;
        end
    endtask

    // Check every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result('{status: out_ch.status, profile: out_ch.profile,
                              compat: out_ch.compat, level: out_ch.level,
                              nal_length_size: out_ch.nal_length_size,
                              ref_frames: out_ch.ref_frames,
                              pixel_width: out_ch.pixel_width,
                              pixel_height: out_ch.pixel_height});
    end

    initial
    begin
        cycles <= 0;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= 8'd0;
        in_ch.last_byte <= 1'b0;
        out_ch.ready <= 1'b0;
        build_stimulus();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            drive_ready();
        join_none
        foreach (feed[i])
            send_item(feed[i]);
        in_ch.valid <= 1'b0;
        // Drain: wait until every prediction has been checked.
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
